// File: rtl/swdfa_pkg.sv
// Shared widths, constants and register codes for the sliding-window DFA core.
package swdfa_pkg;

    localparam int BOX_COUNT   = 4;
    localparam int MAX_BOX     = 64;
    localparam int BOX_SH      = $clog2(BOX_COUNT);
    localparam int BIDX_W      = $clog2(BOX_COUNT);

    localparam int SAMPLE_W = 24;
    localparam int FL_W     = 32;
    localparam int BOX_W    = 7;
    localparam int NSQ_W    = 2 * BOX_W;
    localparam int WIN_W    = BOX_W + BOX_SH;

    // window sum, mean numerator (sum in Q8) and mean in Q8
    localparam int SUM_W = SAMPLE_W + WIN_W;
    localparam int MN_W  = SUM_W + 8;
    localparam int M_W   = 34;

    // profile point, per-box sums and the exact box-level arithmetic
    localparam int Z_W   = 41;
    localparam int HZ    = (Z_W - 1) / 2;
    localparam int SZ_W  = 47;
    localparam int SZZ_W = 88;
    localparam int C_W   = 55;
    localparam int TW    = 112;
    localparam int MB    = 56;
    localparam int DEN_W = 31;
    localparam int SQ_W  = 2 * FL_W;

    // configuration port
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_BOX_LENGTH = '0;
    localparam logic [BOX_W-1:0]     BOX_RESET      = 7'd16;
    localparam logic [BOX_W-1:0]     BOX_MIN        = 7'd2;

endpackage

// File: rtl/swdfa_cell.sv
// One stage of the sample chain: holds a sample and hands it to the next stage.
module swdfa_cell
    import swdfa_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [SAMPLE_W-1:0] d,
    output logic [SAMPLE_W-1:0] q
);

    logic [SAMPLE_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

// File: rtl/swdfa_mul.sv
// Digit-serial multiplier: one DIG-bit digit of b per cycle, product modulo 2^AW.
module swdfa_mul
    import swdfa_pkg::*;
#(
    parameter int AW  = TW,
    parameter int BW  = MB,
    parameter int DIG = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic          done,
    output logic [AW-1:0] p
);

    localparam int STEPS = (BW + DIG - 1) / DIG;
    localparam int CW    = $clog2(STEPS + 1);

    logic [AW-1:0]        acc_reg;
    logic [AW-1:0]        a_sh_reg;
    logic [STEPS*DIG-1:0] b_sh_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(STEPS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg  <= '0;
            a_sh_reg <= a;
            b_sh_reg <= (STEPS*DIG)'(b);
        end else if (cnt_reg != '0) begin
            acc_reg  <= acc_reg + a_sh_reg * AW'(b_sh_reg[DIG-1:0]);
            a_sh_reg <= a_sh_reg << DIG;
            b_sh_reg <= b_sh_reg >> DIG;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// File: rtl/swdfa_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module swdfa_div
    import swdfa_pkg::*;
#(
    parameter int NW = TW,
    parameter int DW = DEN_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic          rem_nz
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, q_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(NW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    assign done   = done_reg;
    assign quo    = q_reg;
    assign rem_nz = rem_reg != '0;

endmodule

// File: rtl/swdfa_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle, rounded down.
module swdfa_sqrt
    import swdfa_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [SQ_W-1:0] din,
    output logic            done,
    output logic [FL_W-1:0] root
);

    localparam int CW = $clog2(FL_W + 1);

    logic [SQ_W-1:0] val_reg;
    logic [FL_W+1:0] rem_reg;
    logic [FL_W-1:0] root_reg;
    logic [CW-1:0]   cnt_reg;
    logic            done_reg;
    logic [FL_W+1:0] rem_t;
    logic [FL_W+1:0] trial;
    logic            ge;

    assign rem_t = {rem_reg[FL_W-1:0], val_reg[SQ_W-1:SQ_W-2]};
    assign trial = {root_reg, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(FL_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= din;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            val_reg  <= val_reg << 2;
            rem_reg  <= ge ? rem_t - trial : rem_t;
            root_reg <= {root_reg[FL_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/sliding_window_dfa_core.sv
// Sliding-window DFA-1 core: window sample chain, profile fit, divide and square root.
// Each item returns the DFA-1 fluctuation (Q24.8, saturating) of the 4*box_length
// samples before it, then joins the window. Samples live in a chain of
// 4*MAX_BOX cells that rotates once per pass: one pass sums the window, a second
// builds the profile and the per-box fit sums. An item whose window is full passes
// through the two chain rotations, the bit-serial mean and final dividers, the
// digit-serial box multiplier and, unless the result saturates, the bit-serial
// square root; an item that comes before a full window returns zero with
// m_valid_res low. One item is worked at a time; the next is taken while the previous
// result waits in the output register. box_length is clamped to 2..MAX_BOX and must
// be written by the user only while the core is idle; the core does not enforce it.
module sliding_window_dfa_core
    import swdfa_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [FL_W-1:0]            m_fluctuation,
    output logic                       m_valid_res
);

    localparam int DEPTH = BOX_COUNT * MAX_BOX;
    localparam int SW    = $clog2(DEPTH);
    localparam int FCW   = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SUM, ST_MGO, ST_MWAIT, ST_PROF, ST_DRAIN, ST_BOX,
        ST_FGO, ST_FWAIT, ST_SGO, ST_SWAIT, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_NSZZ, OP_SZSQ, OP_SCALE, OP_CSQ
    } op_t;

    // ---------------- configuration ----------------
    logic [BOX_W-1:0] box_length_reg;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_BOX_LENGTH) ? APB_DW'(box_length_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_length_reg <= BOX_RESET;
        end else if (cfg_wr && paddr[APB_AW-1:2] == REG_BOX_LENGTH) begin
            box_length_reg <= pwdata[BOX_W-1:0];
        end
    end

    // ---------------- declarations ----------------
    state_t             state_reg;
    op_t                op_reg;
    logic               m_valid_reg;
    logic [FL_W-1:0]    m_fluctuation_reg;
    logic               m_valid_res_reg;
    logic [FCW-1:0]     fill_reg;
    logic [SW-1:0]      step_reg;
    logic [BOX_W-1:0]   i_reg;
    logic [BIDX_W-1:0]  b_reg;
    logic               mwait_reg;
    logic               drain_reg;
    logic               va_reg;
    logic               vb_reg;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [BOX_W-1:0]    n_reg;
    logic [NSQ_W-1:0]    nsq_reg;
    logic [SW:0]         start_reg;
    logic [DEN_W-1:0]    den_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [M_W-1:0]   m_reg;
    logic [FL_W-1:0]     fl_res_reg;
    logic                vres_res_reg;

    logic signed [Z_W-1:0]     z_a_reg;
    logic signed [BOX_W+1:0]   coef_a_reg;
    logic [BIDX_W-1:0]         ba_reg;
    logic [BIDX_W-1:0]         bb_reg;
    logic signed [Z_W-1:0]     zb_reg;
    logic signed [C_W-1:0]     zc_b_reg;
    logic [2*HZ-1:0]           pll_reg;
    logic [2*HZ-1:0]           phl_reg;
    logic [2*HZ-1:0]           phh_reg;

    logic signed [SZ_W-1:0] sz_arr  [BOX_COUNT];
    logic [SZZ_W-1:0]       szz_arr [BOX_COUNT];
    logic signed [C_W-1:0]  c_arr   [BOX_COUNT];

    logic [TW-1:0] acc_reg;
    logic [TW-1:0] total_reg;

    // ---------------- sample chain ----------------
    logic [SAMPLE_W-1:0] cell_q [DEPTH];
    logic [SAMPLE_W-1:0] head_d;
    logic                shift_en;
    logic                out_free;
    logic [SAMPLE_W-1:0] tap;

    assign out_free = !m_valid_reg || m_ready;
    assign tap      = cell_q[DEPTH-1];
    assign shift_en = (state_reg == ST_SUM) || (state_reg == ST_PROF) ||
                      (state_reg == ST_DONE && out_free);
    // push the new sample on the last cycle, otherwise rotate the window
    assign head_d   = (state_reg == ST_DONE) ? sample_reg : tap;

    for (genvar g = 0; g < DEPTH; g++) begin : g_chain
        if (g == 0) begin : g_head
            swdfa_cell u_cell (.aclk(aclk), .en(shift_en), .d(head_d), .q(cell_q[g]));
        end else begin : g_body
            swdfa_cell u_cell (.aclk(aclk), .en(shift_en), .d(cell_q[g-1]), .q(cell_q[g]));
        end
    end

    // ---------------- combinational helpers ----------------
    logic [BOX_W-1:0] n_c;
    logic [WIN_W-1:0] win_c;
    logic             enough;
    logic             in_win;
    logic             last_step;

    always_comb begin
        n_c = box_length_reg;
        if (box_length_reg < BOX_MIN) begin
            n_c = BOX_MIN;
        end else if (int'(box_length_reg) > MAX_BOX) begin
            n_c = BOX_W'(MAX_BOX);
        end
    end

    assign win_c     = WIN_W'(n_c) << BOX_SH;
    assign enough    = 32'(fill_reg) >= 32'(win_c);
    assign in_win    = {1'b0, step_reg} >= start_reg;
    assign last_step = step_reg == SW'(DEPTH - 1);

    logic signed [MN_W-1:0] mnum;
    logic [MN_W-1:0]        mmag;
    logic                   mneg;
    logic signed [M_W-1:0]  mq;
    logic signed [M_W-1:0]  term;
    logic signed [BOX_W+1:0] coef;
    logic [Z_W-1:0]         magz;
    logic [NSQ_W-1:0]       nsqm1;
    logic [2*NSQ_W-1:0]     nprod;

    assign mneg  = sum_reg[SUM_W-1];
    assign mnum  = $signed({sum_reg, 8'b0});
    assign mmag  = mneg ? MN_W'(-mnum) : MN_W'(mnum);
    assign term  = M_W'($signed({tap, 8'b0})) - m_reg;
    assign coef  = $signed({1'b0, i_reg, 1'b0}) - $signed({2'b00, n_reg})
                   + $signed((BOX_W+2)'(1));
    assign magz  = z_a_reg[Z_W-1] ? Z_W'(-z_a_reg) : Z_W'(z_a_reg);
    assign nsqm1 = nsq_reg - 1'b1;
    assign nprod = (2*NSQ_W)'(nsq_reg) * (2*NSQ_W)'(nsqm1);

    // ---------------- arithmetic units ----------------
    logic            mdiv_start, mdiv_done, mdiv_rem_nz;
    logic [MN_W-1:0] mdiv_quo;
    logic            fdiv_start, fdiv_done, fdiv_rem_nz;
    logic [TW-1:0]   fdiv_quo;
    logic            sq_start, sq_done;
    logic [FL_W-1:0] sq_root;
    logic            mul_start, mul_done;
    logic [TW-1:0]   mul_a, mul_p;
    logic [MB-1:0]   mul_b;

    assign mdiv_start = state_reg == ST_MGO;
    assign fdiv_start = state_reg == ST_FGO;
    assign sq_start   = state_reg == ST_SGO;
    assign mul_start  = (state_reg == ST_BOX) && !mwait_reg;

    swdfa_div #(.NW(MN_W), .DW(WIN_W)) u_mean_div (
        .aclk(aclk), .aresetn(aresetn), .start(mdiv_start), .num(mmag),
        .den(WIN_W'(n_reg) << BOX_SH), .done(mdiv_done), .quo(mdiv_quo),
        .rem_nz(mdiv_rem_nz)
    );

    swdfa_div #(.NW(TW), .DW(DEN_W)) u_final_div (
        .aclk(aclk), .aresetn(aresetn), .start(fdiv_start), .num(total_reg),
        .den(den_reg), .done(fdiv_done), .quo(fdiv_quo), .rem_nz(fdiv_rem_nz)
    );

    swdfa_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .din(fdiv_quo[SQ_W-1:0]),
        .done(sq_done), .root(sq_root)
    );

    swdfa_mul #(.AW(TW), .BW(MB), .DIG(8)) u_box_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .p(mul_p)
    );

    logic signed [SZ_W-1:0] sz_sel;
    logic signed [C_W-1:0]  c_sel;
    logic [SZ_W-1:0]        magsz;
    logic [C_W-1:0]         magc;

    assign sz_sel = sz_arr[b_reg];
    assign c_sel  = c_arr[b_reg];
    assign magsz  = sz_sel[SZ_W-1] ? SZ_W'(-sz_sel) : SZ_W'(sz_sel);
    assign magc   = c_sel[C_W-1] ? C_W'(-c_sel) : C_W'(c_sel);

    always_comb begin
        case (op_reg)
            OP_NSZZ: begin
                mul_a = TW'(szz_arr[b_reg]);
                mul_b = MB'(n_reg);
            end
            OP_SZSQ: begin
                mul_a = TW'(magsz);
                mul_b = MB'(magsz);
            end
            OP_SCALE: begin
                mul_a = acc_reg;
                mul_b = MB'(nsqm1);
            end
            OP_CSQ: begin
                mul_a = TW'(magc);
                mul_b = MB'(magc);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_NSZZ;
            m_valid_reg <= 1'b0;
            fill_reg    <= '0;
            step_reg    <= '0;
            i_reg       <= '0;
            b_reg       <= '0;
            mwait_reg   <= 1'b0;
            drain_reg   <= 1'b0;
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
        end else begin
            // drop the taken result unless a new one is loaded this cycle
            if (m_ready && !(state_reg == ST_DONE && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            va_reg <= (state_reg == ST_PROF) && in_win;
            vb_reg <= va_reg;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        step_reg  <= '0;
                        state_reg <= enough ? ST_SUM : ST_DONE;
                    end
                end
                ST_SUM: begin
                    step_reg <= last_step ? '0 : step_reg + 1'b1;
                    if (last_step) begin
                        state_reg <= ST_MGO;
                    end
                end
                ST_MGO: begin
                    state_reg <= ST_MWAIT;
                end
                ST_MWAIT: begin
                    if (mdiv_done) begin
                        i_reg     <= '0;
                        b_reg     <= '0;
                        state_reg <= ST_PROF;
                    end
                end
                ST_PROF: begin
                    step_reg <= last_step ? '0 : step_reg + 1'b1;
                    if (in_win) begin
                        if (i_reg == n_reg - 1'b1) begin
                            i_reg <= '0;
                            b_reg <= b_reg + 1'b1;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    if (last_step) begin
                        drain_reg <= 1'b0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // wait for the fit pipeline to land its last point
                    drain_reg <= 1'b1;
                    if (drain_reg) begin
                        b_reg     <= '0;
                        op_reg    <= OP_NSZZ;
                        mwait_reg <= 1'b0;
                        state_reg <= ST_BOX;
                    end
                end
                ST_BOX: begin
                    if (!mwait_reg) begin
                        mwait_reg <= 1'b1;
                    end else if (mul_done) begin
                        mwait_reg <= 1'b0;
                        case (op_reg)
                            OP_NSZZ:  op_reg <= OP_SZSQ;
                            OP_SZSQ:  op_reg <= OP_SCALE;
                            OP_SCALE: op_reg <= OP_CSQ;
                            default: begin
                                op_reg <= OP_NSZZ;
                                if (b_reg == BIDX_W'(BOX_COUNT - 1)) begin
                                    state_reg <= ST_FGO;
                                end else begin
                                    b_reg <= b_reg + 1'b1;
                                end
                            end
                        endcase
                    end
                end
                ST_FGO: begin
                    state_reg <= ST_FWAIT;
                end
                ST_FWAIT: begin
                    if (fdiv_done) begin
                        state_reg <= (fdiv_quo[TW-1:SQ_W] != '0) ? ST_DONE : ST_SGO;
                    end
                end
                ST_SGO: begin
                    state_reg <= ST_SWAIT;
                end
                ST_SWAIT: begin
                    if (sq_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        m_fluctuation_reg <= fl_res_reg;
                        m_valid_res_reg   <= vres_res_reg;
                        if (fill_reg != FCW'(DEPTH)) begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            sample_reg <= s_sample;
            n_reg      <= n_c;
            nsq_reg    <= NSQ_W'(n_c) * NSQ_W'(n_c);
            start_reg  <= (SW+1)'(DEPTH) - (SW+1)'(win_c);
            sum_reg    <= '0;
            if (!enough) begin
                fl_res_reg   <= '0;
                vres_res_reg <= 1'b0;
            end
        end

        if (state_reg == ST_SUM) begin
            den_reg <= DEN_W'(nprod) << BOX_SH;
            if (in_win) begin
                sum_reg <= sum_reg + SUM_W'($signed(tap));
            end
        end

        if (state_reg == ST_MWAIT && mdiv_done) begin
            // floor toward minus infinity for a negative sum
            m_reg <= mneg ? -mq : mq;
            total_reg <= '0;
            for (int k = 0; k < BOX_COUNT; k++) begin
                sz_arr[k]  <= '0;
                szz_arr[k] <= '0;
                c_arr[k]   <= '0;
            end
        end

        // fit pipeline, stage A: running profile point relative to box start
        if (state_reg == ST_PROF && in_win) begin
            z_a_reg    <= (i_reg == '0) ? '0 : z_a_reg + Z_W'(term);
            coef_a_reg <= coef;
            ba_reg     <= b_reg;
        end

        // stage B: products
        bb_reg   <= ba_reg;
        zb_reg   <= z_a_reg;
        zc_b_reg <= C_W'(coef_a_reg) * C_W'(z_a_reg);
        pll_reg  <= magz[HZ-1:0] * magz[HZ-1:0];
        phl_reg  <= magz[2*HZ-1:HZ] * magz[HZ-1:0];
        phh_reg  <= magz[2*HZ-1:HZ] * magz[2*HZ-1:HZ];

        // stage C: per-box sums
        if (vb_reg) begin
            sz_arr[bb_reg]  <= sz_arr[bb_reg] + SZ_W'(zb_reg);
            szz_arr[bb_reg] <= szz_arr[bb_reg] + (SZZ_W'(phh_reg) << (2*HZ))
                               + (SZZ_W'(phl_reg) << (HZ+1)) + SZZ_W'(pll_reg);
            c_arr[bb_reg]   <= c_arr[bb_reg] + zc_b_reg;
        end

        if (state_reg == ST_BOX && mwait_reg && mul_done) begin
            case (op_reg)
                OP_NSZZ:  acc_reg <= mul_p;
                OP_SZSQ:  acc_reg <= acc_reg - mul_p;
                OP_SCALE: acc_reg <= mul_p;
                OP_CSQ:   total_reg <= total_reg + acc_reg - (mul_p << 1) - mul_p;
                default:  acc_reg <= acc_reg;
            endcase
        end

        if (state_reg == ST_FWAIT && fdiv_done) begin
            fl_res_reg   <= {FL_W{1'b1}};
            vres_res_reg <= 1'b1;
        end

        if (state_reg == ST_SWAIT && sq_done) begin
            fl_res_reg   <= sq_root;
            vres_res_reg <= 1'b1;
        end
    end

    assign mq = M_W'(mdiv_quo) + M_W'(mdiv_rem_nz && mneg);

    assign s_ready       = state_reg == ST_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_fluctuation = m_fluctuation_reg;
    assign m_valid_res   = m_valid_res_reg;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_fluctuation == '0)
        else $error("invalid result carries nonzero fluctuation");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FCW'(DEPTH))
        else $error("fill count past chain depth");

    a_mean_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mdiv_done |-> state_reg == ST_MWAIT)
        else $error("mean divider finished outside its wait state");

    a_fit_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BOX |-> !va_reg && !vb_reg)
        else $error("fit pipeline still busy during box reduction");
`endif

endmodule

// File: tb/sv/sliding_window_dfa_core_tb.sv
// Self-checking testbench for the sliding-window DFA-1 core.
module sliding_window_dfa_core_tb;
    import swdfa_pkg::*;

    localparam int RING_CELLS   = BOX_COUNT * MAX_BOX;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int DRAIN_CYCLES = 1000;
    localparam int PHASE_ITEMS  = 30;
    localparam int SQUARE_ITEMS = 260;

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        bit                         typed;
        logic [FL_W-1:0]            fl;
        logic                       vr;
    } stim_row_t;

    typedef struct {
        logic [FL_W-1:0] fl;
        logic            vr;
    } fluct_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [FL_W-1:0] m_fluctuation;
    logic m_valid_res;

    sliding_window_dfa_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_fluctuation(m_fluctuation), .m_valid_res(m_valid_res)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the core's window and register
    int              win_ring [RING_CELLS];
    int              win_wptr = 0;
    int              win_fill = 0;
    logic [BOX_W-1:0] box_shadow = BOX_RESET;

    fluct_t pending_fluct[$];
    int     errors = 0;
    int     accepted = 0;
    bit     quiet = 1'b0;
    bit     done_stim = 1'b0;
    int     cycles = 0;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // compute the fluctuation over the window, then push the sample
    function automatic fluct_t dfa_step(input logic signed [SAMPLE_W-1:0] smp);
        fluct_t r;
        int n, w, base, k, b, i;
        longint sum, num, m, zv, sz, cc;
        logic signed [127:0] nn, z128, s128, c128, szz, part, total, den;
        logic [127:0] q;
        n = int'(box_shadow);
        if (n < 2) n = 2;
        if (n > MAX_BOX) n = MAX_BOX;
        w = BOX_COUNT * n;
        r.fl = '0;
        r.vr = 1'b0;
        if (win_fill >= w) begin
            base = (win_wptr + RING_CELLS - w) % RING_CELLS;
            sum = 0;
            for (k = 0; k < w; k++) sum += win_ring[(base + k) % RING_CELLS];
            num = sum * 256;
            m = num / w;
            if (num % w != 0 && num < 0) m -= 1;
            nn = 128'(n);
            total = 0;
            for (b = 0; b < BOX_COUNT; b++) begin
                zv = 0; sz = 0; cc = 0; szz = 0;
                for (i = 0; i < n; i++) begin
                    if (i > 0)
                        zv += longint'(win_ring[(base + b * n + i) % RING_CELLS]) * 256 - m;
                    sz += zv;
                    z128 = 128'(zv);
                    szz += z128 * z128;
                    cc += longint'(2 * i - n + 1) * zv;
                end
                s128 = 128'(sz);
                c128 = 128'(cc);
                part = (nn * szz - s128 * s128) * (nn * nn - 1) - 3 * c128 * c128;
                total += part;
            end
            den = 4 * nn * nn * (nn * nn - 1);
            q = total / den;
            if (q[127:64] != 0) r.fl = '1;
            else r.fl = FL_W'(floor_sqrt(q[63:0]));
            r.vr = 1'b1;
        end
        win_ring[win_wptr] = int'(smp);
        win_wptr = (win_wptr + 1) % RING_CELLS;
        if (win_fill < RING_CELLS) win_fill++;
        return r;
    endfunction

    task automatic apb_write(input int idx, input logic [APB_DW-1:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= APB_AW'(4 * idx); pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == int'(REG_BOX_LENGTH)) box_shadow = val[BOX_W-1:0];
    endtask

    // hold valid until the item is taken, then record the expectation
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp,
                               input bit typed, input fluct_t typed_res);
        fluct_t r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!(s_valid && s_ready));
        r = dfa_step(smp);
        if (typed) r = typed_res;
        pending_fluct = {pending_fluct, r};
        accepted++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_fluct.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
            input logic signed [SAMPLE_W-1:0] prev);
        case ($urandom_range(0, 3))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return prev;
        endcase
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_fluct.size() == 0) begin
                $display("%0t: unexpected result fluctuation=%h valid_res=%b",
                         $time, m_fluctuation, m_valid_res);
                errors++;
            end else begin
                fluct_t e;
                e = pending_fluct.pop_front();
                if (m_fluctuation !== e.fl) begin
                    $display("%0t: fluctuation expected %h actual %h",
                             $time, e.fl, m_fluctuation);
                    errors++;
                end
                if (m_valid_res !== e.vr) begin
                    $display("%0t: valid_res expected %b actual %b",
                             $time, e.vr, m_valid_res);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off to back up the input
    initial begin
        bit held;
        held = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && accepted >= 150) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        fluct_t none;
        int phase_box[8] = '{0, 2, 1, 64, 127, 5, 33, 16};
        logic signed [SAMPLE_W-1:0] prev;
        logic signed [SAMPLE_W-1:0] dir_vals[20] = '{
            24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF, 24'sh000001,
            24'sh555555, 24'shAAAAAA, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
            24'sh800000, 24'sh000100, 24'shFFFF00, 24'sh400000, 24'shC00000,
            24'sh0F0F0F, 24'shF0F0F0, 24'sh000000, 24'sh123456, 24'shEDCBA9};
        int p, j;

        // window not yet full after reset: every result flagged invalid
        foreach (dir_vals[j]) begin
            row.smp = dir_vals[j]; row.typed = 1'b1; row.fl = '0; row.vr = 1'b0;
            rows = {rows, row};
        end
        none.fl = '0;
        none.vr = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[j]) begin
            none.fl = rows[j].fl;
            none.vr = rows[j].vr;
            send_sample(rows[j].smp, rows[j].typed, none);
        end

        prev = '0;
        for (p = 0; p < 8; p++) begin
            wait_idle();
            if (p == 7) quiet = 1'b1;
            apb_write(int'(REG_BOX_LENGTH), APB_DW'(phase_box[p]));
            // square wave across each box drives the result into saturation
            if (phase_box[p] == 64) begin
                for (j = 0; j < SQUARE_ITEMS; j++)
                    send_sample((j % 64) < 32 ? 24'sh7FFFFF : 24'sh800000, 1'b0, none);
            end
            for (j = 0; j < PHASE_ITEMS; j++) begin
                prev = pick_sample(prev);
                send_sample(prev, 1'b0, none);
            end
        end
        s_valid <= 1'b0;

        while (pending_fluct.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/swdfa_pkg.sv
rtl/swdfa_cell.sv
rtl/swdfa_mul.sv
rtl/swdfa_div.sv
rtl/swdfa_sqrt.sv
rtl/sliding_window_dfa_core.sv
tb/sv/sliding_window_dfa_core_tb.sv
